@@ rtl/hsl2rgb_pkg.sv @@
// ============================================================================
// hsl2rgb_pkg
// Shared widths, stage indexes and control types for the HSL to RGB pipeline.
// ============================================================================
package hsl2rgb_pkg;

    // Input and output field widths
    localparam int IN_W  = 17;
    localparam int OUT_W = 8;

    // Full scale of the 0..360 inputs in Q.8 (360 * 256)
    localparam int IN_MAX = 92160;

    // Default fraction width of the internal fixed point
    localparam int FRAC_BITS_DEF = 16;

    // Pipeline stages
    localparam int NUM_STAGES   = 6;
    localparam int ST_NORM_MUL  = 0;   // clamp and reciprocal multiply
    localparam int ST_NORM_FIX  = 1;   // quotient correction
    localparam int ST_MIX       = 2;   // temporaries and hue offsets
    localparam int ST_PREP      = 3;   // segment select and slope operand
    localparam int ST_MUL       = 4;   // slope multiply
    localparam int ST_OUT       = 5;   // interpolate, scale, clamp

    typedef logic [OUT_W-1:0] chan_byte_t;

    // Pipeline control from the stage controller to the datapath
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;    // stage register takes new data
        logic [NUM_STAGES-1:0] valid;   // stage register holds an item
    } hsl2rgb_ctl_t;

endpackage

@@ rtl/hsl2rgb_ctrl.sv @@
// ============================================================================
// hsl2rgb_ctrl
// Valid/ready control for the stage chain. Each stage loads when it is empty
// or its successor loads, so bubbles collapse under a stalled output.
// ============================================================================
module hsl2rgb_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  logic                      m_ready,
    output hsl2rgb_pkg::hsl2rgb_ctl_t ctl
);

    localparam int N = hsl2rgb_pkg::NUM_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N:0]   rdy;
    logic [N-1:0] load;

    // Ready chain from the output back to the input
    always_comb begin
        rdy[N] = m_ready;
        for (int i = N - 1; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    // Next valid bits and load strobes
    always_comb begin
        valid_next[0] = rdy[0] ? s_valid : valid_reg[0];
        load[0]       = rdy[0] && s_valid;
        for (int i = 1; i < N; i++) begin
            valid_next[i] = rdy[i] ? valid_reg[i-1] : valid_reg[i];
            load[i]       = rdy[i] && valid_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready   = rdy[0];
    assign m_valid   = valid_reg[N-1];
    assign ctl.load  = load;
    assign ctl.valid = valid_reg;

endmodule

@@ rtl/hsl2rgb_norm.sv @@
// ============================================================================
// hsl2rgb_norm
// Clamps a Q.8 value on the 0..360 scale and normalizes it to 0..1 with
// FRAC_BITS fraction bits: reciprocal multiply, then a one-step correction.
// ============================================================================
module hsl2rgb_norm #(
    parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic [1:0]                     load,
    input  logic [hsl2rgb_pkg::IN_W-1:0]   x,
    output logic [FRAC_BITS:0]             v
);

    localparam int IN_W   = hsl2rgb_pkg::IN_W;
    localparam int V_W    = FRAC_BITS + 1;
    localparam int PROD_W = IN_W + V_W;
    localparam int N_W    = IN_W + FRAC_BITS;

    // floor(2^(FRAC_BITS+IN_W) / full scale), fits in V_W bits
    localparam longint unsigned RECIP =
        (64'd1 << (FRAC_BITS + IN_W)) / hsl2rgb_pkg::IN_MAX;
    localparam logic [V_W-1:0]  RECIP_C  = V_W'(RECIP);
    localparam logic [IN_W-1:0] IN_MAX_C = IN_W'(hsl2rgb_pkg::IN_MAX);
    localparam logic [N_W-1:0]  IN_MAX_N = N_W'(hsl2rgb_pkg::IN_MAX);

    logic [IN_W-1:0]   xc;
    logic [PROD_W-1:0] prod;
    logic [IN_W-1:0]   xc_reg;
    logic [V_W-1:0]    q_est_reg;
    logic [N_W-1:0]    numer;
    logic [N_W-1:0]    back;
    logic [N_W-1:0]    rem;
    logic              fix;
    logic [V_W-1:0]    v_reg;

    // Stage 1: saturate and multiply by the reciprocal
    assign xc   = (x > IN_MAX_C) ? IN_MAX_C : x;
    assign prod = PROD_W'(xc) * PROD_W'(RECIP_C);

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            xc_reg    <= xc;
            q_est_reg <= prod[PROD_W-1:IN_W];
        end
    end

    // Stage 2: estimate is exact or one low; the remainder decides
    assign numer = {xc_reg, {FRAC_BITS{1'b0}}};
    assign back  = N_W'(q_est_reg) * IN_MAX_N;
    assign rem   = numer - back;
    assign fix   = (rem >= IN_MAX_N);

    always_ff @(posedge aclk) begin
        if (load[1]) begin
            v_reg <= q_est_reg + V_W'(fix);
        end
    end

    assign v = v_reg;

endmodule

@@ rtl/hsl2rgb_mix.sv @@
// ============================================================================
// hsl2rgb_mix
// Forms the two HSL temporaries from lightness and saturation and the three
// hue positions (+1/3, 0, -1/3) wrapped once into 0..1.
// ============================================================================
module hsl2rgb_mix #(
    parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        load,
    input  logic [FRAC_BITS:0]          hue,
    input  logic [FRAC_BITS:0]          sat,
    input  logic [FRAC_BITS:0]          lum,
    output logic signed [FRAC_BITS+2:0] t1,
    output logic signed [FRAC_BITS+2:0] t2,
    output logic [FRAC_BITS:0]          t_red,
    output logic [FRAC_BITS:0]          t_green,
    output logic [FRAC_BITS:0]          t_blue
);

    localparam int V_W = FRAC_BITS + 1;
    localparam int S_W = FRAC_BITS + 3;
    localparam int P_W = 2 * V_W;

    localparam logic [V_W-1:0] ONE   = V_W'(64'd1 << FRAC_BITS);
    localparam logic [V_W-1:0] HALF  = V_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic [V_W-1:0] THIRD = V_W'((64'd1 << FRAC_BITS) / 3);

    logic [P_W-1:0]        ls_prod;
    logic [V_W-1:0]        ls;
    logic signed [S_W-1:0] lum_s;
    logic signed [S_W-1:0] sat_s;
    logic signed [S_W-1:0] ls_s;
    logic signed [S_W-1:0] t2_c;
    logic signed [S_W-1:0] t1_c;
    logic [V_W:0]          hue_up;
    logic [V_W-1:0]        red_c;
    logic [V_W-1:0]        blue_c;

    logic signed [S_W-1:0] t1_reg;
    logic signed [S_W-1:0] t2_reg;
    logic [V_W-1:0]        red_reg;
    logic [V_W-1:0]        green_reg;
    logic [V_W-1:0]        blue_reg;

    // Temporaries; zero lightness or saturation falls out as black or grey
    assign ls_prod = P_W'(lum) * P_W'(sat);
    assign ls      = ls_prod[FRAC_BITS +: V_W];
    assign lum_s   = $signed({2'b00, lum});
    assign sat_s   = $signed({2'b00, sat});
    assign ls_s    = $signed({2'b00, ls});
    assign t2_c    = (lum < HALF) ? (lum_s + ls_s) : (lum_s + sat_s - ls_s);
    assign t1_c    = (lum_s <<< 1) - t2_c;

    // Hue offsets, wrapped once
    assign hue_up = {1'b0, hue} + {1'b0, THIRD};
    assign red_c  = (hue_up > {1'b0, ONE}) ? V_W'(hue_up - {1'b0, ONE}) : V_W'(hue_up);
    assign blue_c = (hue < THIRD) ? V_W'({1'b0, hue} + {1'b0, ONE} - {1'b0, THIRD})
                                  : (hue - THIRD);

    always_ff @(posedge aclk) begin
        if (load) begin
            t1_reg    <= t1_c;
            t2_reg    <= t2_c;
            red_reg   <= red_c;
            green_reg <= hue;
            blue_reg  <= blue_c;
        end
    end

    assign t1      = t1_reg;
    assign t2      = t2_reg;
    assign t_red   = red_reg;
    assign t_green = green_reg;
    assign t_blue  = blue_reg;

endmodule

@@ rtl/hsl2rgb_chan.sv @@
// ============================================================================
// hsl2rgb_chan
// One color channel: piecewise interpolation between the temporaries at a
// hue position, then scaling by 255 with floor and clamp to a byte.
// ============================================================================
module hsl2rgb_chan #(
    parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic [2:0]                  load,
    input  logic signed [FRAC_BITS+2:0] t1,
    input  logic signed [FRAC_BITS+2:0] t2,
    input  logic [FRAC_BITS:0]          t,
    output hsl2rgb_pkg::chan_byte_t     chan
);

    localparam int V_W  = FRAC_BITS + 1;
    localparam int S_W  = FRAC_BITS + 3;
    localparam int M_W  = FRAC_BITS + 4;
    localparam int P_W  = S_W + V_W + 1;
    localparam int C_W  = S_W + 1;
    localparam int SC_W = C_W + 9;

    localparam logic [V_W-1:0] SIXTH      = V_W'((64'd1 << FRAC_BITS) / 6);
    localparam logic [V_W-1:0] HALF       = V_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic [V_W-1:0] TWO_THIRDS = V_W'((64'd2 << FRAC_BITS) / 3);
    localparam logic [M_W-1:0] SIX        = M_W'(6);

    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } seg_t;

    // Stage A signals
    seg_t                  seg_c;
    logic [M_W-1:0]        m_c;
    seg_t                  seg_a_reg;
    logic [V_W-1:0]        m_a_reg;
    logic signed [S_W-1:0] d_a_reg;
    logic signed [S_W-1:0] t1_a_reg;
    logic signed [S_W-1:0] t2_a_reg;

    // Stage B signals
    logic signed [P_W-1:0] prod;
    logic signed [P_W-1:0] prod_sh;
    seg_t                  seg_b_reg;
    logic signed [S_W-1:0] q_b_reg;
    logic signed [S_W-1:0] t1_b_reg;
    logic signed [S_W-1:0] t2_b_reg;

    // Stage C signals
    logic signed [C_W-1:0]  c;
    logic signed [SC_W-1:0] scaled;
    logic signed [SC_W-1:0] b;
    hsl2rgb_pkg::chan_byte_t byte_c;
    hsl2rgb_pkg::chan_byte_t chan_reg;

    // Stage A: pick the segment and the slope operand
    always_comb begin
        if (t < SIXTH) begin
            seg_c = SEG_RISE;
            m_c   = M_W'(t) * SIX;
        end else if (t < HALF) begin
            seg_c = SEG_HIGH;
            m_c   = '0;
        end else if (t < TWO_THIRDS) begin
            seg_c = SEG_FALL;
            m_c   = M_W'(TWO_THIRDS - t) * SIX;
        end else begin
            seg_c = SEG_LOW;
            m_c   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            seg_a_reg <= seg_c;
            m_a_reg   <= m_c[V_W-1:0];
            d_a_reg   <= t2 - t1;
            t1_a_reg  <= t1;
            t2_a_reg  <= t2;
        end
    end

    // Stage B: slope times offset, floored
    assign prod    = P_W'(d_a_reg) * P_W'($signed({1'b0, m_a_reg}));
    assign prod_sh = prod >>> FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (load[1]) begin
            seg_b_reg <= seg_a_reg;
            q_b_reg   <= prod_sh[S_W-1:0];
            t1_b_reg  <= t1_a_reg;
            t2_b_reg  <= t2_a_reg;
        end
    end

    // Stage C: component value, then floor(255 * c) clamped to a byte
    always_comb begin
        case (seg_b_reg) inside
            SEG_RISE, SEG_FALL: c = C_W'(t1_b_reg) + C_W'(q_b_reg);
            SEG_HIGH:           c = C_W'(t2_b_reg);
            default:            c = C_W'(t1_b_reg);
        endcase
    end

    assign scaled = (SC_W'(c) <<< 8) - SC_W'(c);
    assign b      = scaled >>> FRAC_BITS;

    always_comb begin
        if (b[SC_W-1]) begin
            byte_c = '0;
        end else if (b > SC_W'(255)) begin
            byte_c = '1;
        end else begin
            byte_c = b[hsl2rgb_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (load[2]) begin
            chan_reg <= byte_c;
        end
    end

    assign chan = chan_reg;

endmodule

@@ rtl/hsl_to_rgb_converter_unit.sv @@
// ============================================================================
// hsl_to_rgb_converter_unit
// HSL (Q.8, 0..360 scale) to 8-bit RGB conversion pipeline.
// ============================================================================
// Six register stages: reciprocal multiply, quotient correction, mix,
// segment select, slope multiply, output. Throughput: one pixel per clock
// while the output is not stalled.
// A stalled output holds its result while empty stages still take input.
// Reset (synchronous, active low) clears the stage valid bits only.
module hsl_to_rgb_converter_unit #(
    parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [hsl2rgb_pkg::IN_W-1:0] s_hue_q,
    input  logic [hsl2rgb_pkg::IN_W-1:0] s_saturation_q,
    input  logic [hsl2rgb_pkg::IN_W-1:0] s_lightness_q,
    output logic                         m_valid,
    input  logic                         m_ready,
    output hsl2rgb_pkg::chan_byte_t      m_red,
    output hsl2rgb_pkg::chan_byte_t      m_green,
    output hsl2rgb_pkg::chan_byte_t      m_blue
);

    hsl2rgb_pkg::hsl2rgb_ctl_t ctl;

    logic [FRAC_BITS:0]          hue_n;
    logic [FRAC_BITS:0]          sat_n;
    logic [FRAC_BITS:0]          lum_n;
    logic signed [FRAC_BITS+2:0] t1;
    logic signed [FRAC_BITS+2:0] t2;
    logic [FRAC_BITS:0]          t_red;
    logic [FRAC_BITS:0]          t_green;
    logic [FRAC_BITS:0]          t_blue;

    // Stage control
    hsl2rgb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    // Normalization of the three inputs
    hsl2rgb_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_hue (
        .aclk (aclk),
        .load (ctl.load[hsl2rgb_pkg::ST_NORM_FIX:hsl2rgb_pkg::ST_NORM_MUL]),
        .x    (s_hue_q),
        .v    (hue_n)
    );

    hsl2rgb_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_sat (
        .aclk (aclk),
        .load (ctl.load[hsl2rgb_pkg::ST_NORM_FIX:hsl2rgb_pkg::ST_NORM_MUL]),
        .x    (s_saturation_q),
        .v    (sat_n)
    );

    hsl2rgb_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_lum (
        .aclk (aclk),
        .load (ctl.load[hsl2rgb_pkg::ST_NORM_FIX:hsl2rgb_pkg::ST_NORM_MUL]),
        .x    (s_lightness_q),
        .v    (lum_n)
    );

    // Temporaries and hue positions
    hsl2rgb_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
        .aclk    (aclk),
        .load    (ctl.load[hsl2rgb_pkg::ST_MIX]),
        .hue     (hue_n),
        .sat     (sat_n),
        .lum     (lum_n),
        .t1      (t1),
        .t2      (t2),
        .t_red   (t_red),
        .t_green (t_green),
        .t_blue  (t_blue)
    );

    // Channel lanes
    hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_red (
        .aclk (aclk),
        .load (ctl.load[hsl2rgb_pkg::ST_OUT:hsl2rgb_pkg::ST_PREP]),
        .t1   (t1),
        .t2   (t2),
        .t    (t_red),
        .chan (m_red)
    );

    hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_green (
        .aclk (aclk),
        .load (ctl.load[hsl2rgb_pkg::ST_OUT:hsl2rgb_pkg::ST_PREP]),
        .t1   (t1),
        .t2   (t2),
        .t    (t_green),
        .chan (m_green)
    );

    hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_blue (
        .aclk (aclk),
        .load (ctl.load[hsl2rgb_pkg::ST_OUT:hsl2rgb_pkg::ST_PREP]),
        .t1   (t1),
        .t2   (t2),
        .t    (t_blue),
        .chan (m_blue)
    );

    // Checks: occupancy follows the transfers, a full stalled pipe blocks input
    logic in_xfer;
    logic out_xfer;

    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid && m_ready;

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&ctl.valid && !m_ready) |-> !s_ready)
        else $error("input taken while every stage is full and stalled");

    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && !out_xfer) |=>
            ($countones(ctl.valid) == $past($countones(ctl.valid)) + 1))
        else $error("pipeline occupancy did not grow on an input transfer");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (!in_xfer && out_xfer) |=>
            ($countones(ctl.valid) + 1 == $past($countones(ctl.valid))))
        else $error("pipeline occupancy did not shrink on an output transfer");

endmodule
